FILE: rtl/dpbp_pkg.sv
// ============================================================================
// dpbp_pkg - shared types and constants for depth pixel back-projection
// Payload structs, register map, reset values and pipeline control bundle.
// ============================================================================
package dpbp_pkg;

    // Input pixel payload
    typedef struct packed {
        logic [15:0] depth_mm;
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
        logic [15:0] class_label;
    } in_t;

    // Output point payload
    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic [19:0]        z_pos;
        logic               is_sidewalk;
    } out_t;

    // Register map (index = paddr / 4)
    localparam int unsigned AddrWidth = 5;
    localparam int unsigned IdxWidth  = 3;

    typedef enum logic [IdxWidth-1:0] {
        REG_PRINCIPAL_X = 3'd0,
        REG_PRINCIPAL_Y = 3'd1,
        REG_INV_FOCAL_X = 3'd2,
        REG_INV_FOCAL_Y = 3'd3,
        REG_SIDEWALK    = 3'd4
    } reg_idx_t;

    // Reset values
    localparam logic [15:0] PrincipalXReset = 16'd5120;
    localparam logic [15:0] PrincipalYReset = 16'd3840;
    localparam logic [24:0] InvFocalXReset  = 25'd27280;
    localparam logic [24:0] InvFocalYReset  = 25'd27280;
    localparam logic [15:0] SidewalkReset   = 16'd1;

    // Configuration bundle from register file to datapath
    typedef struct packed {
        logic [15:0] principal_x_q4;
        logic [15:0] principal_y_q4;
        logic [24:0] inv_focal_x;
        logic [24:0] inv_focal_y;
        logic [15:0] sidewalk_class;
    } cfg_t;

    // Per-stage load enables of the four-stage pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

endpackage

FILE: rtl/dpbp_cfg.sv
// ============================================================================
// dpbp_cfg - APB configuration registers
// Five camera registers; write on access phase, zero-wait read back.
// ============================================================================
module dpbp_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dpbp_pkg::AddrWidth-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output dpbp_pkg::cfg_t                    cfg
);

    dpbp_pkg::cfg_t                     cfg_reg;
    dpbp_pkg::cfg_t                     cfg_next;
    logic                               wr_en;
    logic [dpbp_pkg::IdxWidth-1:0]      idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[dpbp_pkg::AddrWidth-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                dpbp_pkg::REG_PRINCIPAL_X: cfg_next.principal_x_q4 = pwdata[15:0];
                dpbp_pkg::REG_PRINCIPAL_Y: cfg_next.principal_y_q4 = pwdata[15:0];
                dpbp_pkg::REG_INV_FOCAL_X: cfg_next.inv_focal_x    = pwdata[24:0];
                dpbp_pkg::REG_INV_FOCAL_Y: cfg_next.inv_focal_y    = pwdata[24:0];
                dpbp_pkg::REG_SIDEWALK:    cfg_next.sidewalk_class = pwdata[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.principal_x_q4 <= dpbp_pkg::PrincipalXReset;
            cfg_reg.principal_y_q4 <= dpbp_pkg::PrincipalYReset;
            cfg_reg.inv_focal_x    <= dpbp_pkg::InvFocalXReset;
            cfg_reg.inv_focal_y    <= dpbp_pkg::InvFocalYReset;
            cfg_reg.sidewalk_class <= dpbp_pkg::SidewalkReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            dpbp_pkg::REG_PRINCIPAL_X: prdata = {16'd0, cfg_reg.principal_x_q4};
            dpbp_pkg::REG_PRINCIPAL_Y: prdata = {16'd0, cfg_reg.principal_y_q4};
            dpbp_pkg::REG_INV_FOCAL_X: prdata = {7'd0, cfg_reg.inv_focal_x};
            dpbp_pkg::REG_INV_FOCAL_Y: prdata = {7'd0, cfg_reg.inv_focal_y};
            dpbp_pkg::REG_SIDEWALK:    prdata = {16'd0, cfg_reg.sidewalk_class};
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/dpbp_lane.sv
// ============================================================================
// dpbp_lane - one axis of the back-projection
// Offset from principal point, depth*offset, times reciprocal, round/saturate.
// ============================================================================
module dpbp_lane #(
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  logic                clk,
    input  dpbp_pkg::pipe_en_t  en,
    input  logic [11:0]         pix,
    input  logic [15:0]         centre_q4,
    input  logic [24:0]         inv_focal,
    input  logic [15:0]         depth,
    output logic signed [31:0]  result
);

    localparam logic [16:0] MaxDim   = 17'(MAX_DIMENSION);
    localparam logic [11:0] ClampVal = 12'(MAX_DIMENSION - 1);

    // stage 1: clamp and signed offset as sign + magnitude
    logic [11:0] pix_c;
    logic [15:0] pq;
    logic        neg1_next;
    logic [15:0] mag1_next;
    logic        neg1_reg;
    logic [15:0] mag1_reg;
    logic [15:0] depth1_reg;

    assign pix_c     = ({5'd0, pix} >= MaxDim) ? ClampVal : pix;
    assign pq        = {pix_c, 4'd0};
    assign neg1_next = pq < centre_q4;
    assign mag1_next = neg1_next ? (centre_q4 - pq) : (pq - centre_q4);

    // stage 2: depth * magnitude
    logic        neg2_reg;
    logic [31:0] dm2_next;
    logic [31:0] dm2_reg;

    assign dm2_next = {16'd0, depth1_reg} * {16'd0, mag1_reg};

    // stage 3: times reciprocal focal length (32 x 25)
    logic        neg3_reg;
    logic [56:0] prod3_next;
    logic [56:0] prod3_reg;

    assign prod3_next = 57'(dm2_reg) * 57'(inv_focal);

    // stage 4: round half away from zero on magnitude, apply sign, saturate
    logic [56:0]        rnd;
    logic [32:0]        q;
    logic signed [31:0] res4_next;
    logic signed [31:0] res4_reg;

    assign rnd = prod3_reg + 57'(1 << 23);
    assign q   = rnd[56:24];

    always_comb
    begin
        if (neg3_reg)
        begin
            if (q > 33'h0_8000_0000)
                res4_next = 32'sh8000_0000;
            else
                res4_next = signed'(32'(33'd0 - q));
        end
        else
        begin
            if (q > 33'h0_7FFF_FFFF)
                res4_next = 32'sh7FFF_FFFF;
            else
                res4_next = signed'(q[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            neg1_reg   <= neg1_next;
            mag1_reg   <= mag1_next;
            depth1_reg <= depth;
        end
        if (en.s2)
        begin
            neg2_reg <= neg1_reg;
            dm2_reg  <= dm2_next;
        end
        if (en.s3)
        begin
            neg3_reg  <= neg2_reg;
            prod3_reg <= prod3_next;
        end
        if (en.s4)
        begin
            res4_reg <= res4_next;
        end
    end

    assign result = res4_reg;

endmodule

FILE: rtl/depth_pixel_back_projection.sv
// ============================================================================
// depth_pixel_back_projection - pinhole back-projection of depth pixels
// Turns (depth, row, col, class) into X/Y/Z in 1/16 mm plus a sidewalk flag.
// ============================================================================
// One pixel per clock while the output is not stalled. Each axis is a
// four-stage pipeline: offset from the principal point, depth times offset
// (16x16), times the reciprocal focal length (32x25), then rounding and
// saturation into the output register. Ready is chained backward stage by
// stage, so bubbles are squeezed out and a stalled output only holds the
// stages behind it once they are full. Camera registers must be written
// over APB while no transfer is in flight; the block does not enforce it.
// ============================================================================
module depth_pixel_back_projection #(
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // pixel input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  dpbp_pkg::in_t                     in_data,

    // point output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output dpbp_pkg::out_t                    out_data,

    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dpbp_pkg::AddrWidth-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    dpbp_pkg::cfg_t     cfg;
    dpbp_pkg::pipe_en_t en;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    // stage ready: a stage may load when empty or when it drains this cycle
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign in_ready = rdy1;

    // load a stage only when something valid moves in
    assign en.s1 = rdy1 && in_valid;
    assign en.s2 = rdy2 && v1_reg;
    assign en.s3 = rdy3 && v2_reg;
    assign en.s4 = rdy4 && v3_reg;

    assign v1_next = rdy1 ? in_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg   : v2_reg;
    assign v3_next = rdy3 ? v2_reg   : v3_reg;
    assign v4_next = rdy4 ? v3_reg   : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    dpbp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic signed [31:0] x_res;
    logic signed [31:0] y_res;

    // X from column, Y from row
    dpbp_lane #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_lane_x (
        .clk       (clk),
        .en        (en),
        .pix       (in_data.pixel_col),
        .centre_q4 (cfg.principal_x_q4),
        .inv_focal (cfg.inv_focal_x),
        .depth     (in_data.depth_mm),
        .result    (x_res)
    );

    dpbp_lane #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_lane_y (
        .clk       (clk),
        .en        (en),
        .pix       (in_data.pixel_row),
        .centre_q4 (cfg.principal_y_q4),
        .inv_focal (cfg.inv_focal_y),
        .depth     (in_data.depth_mm),
        .result    (y_res)
    );

    // Z and the sidewalk flag are settled in stage 1 and ride along
    logic [19:0] z1_reg, z2_reg, z3_reg, z4_reg;
    logic        sw1_reg, sw2_reg, sw3_reg, sw4_reg;
    logic [19:0] z1_next;
    logic        sw1_next;

    assign z1_next  = {in_data.depth_mm, 4'd0};
    assign sw1_next = (in_data.class_label == cfg.sidewalk_class);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            z1_reg  <= z1_next;
            sw1_reg <= sw1_next;
        end
        if (en.s2)
        begin
            z2_reg  <= z1_reg;
            sw2_reg <= sw1_reg;
        end
        if (en.s3)
        begin
            z3_reg  <= z2_reg;
            sw3_reg <= sw2_reg;
        end
        if (en.s4)
        begin
            z4_reg  <= z3_reg;
            sw4_reg <= sw3_reg;
        end
    end

    assign out_valid            = v4_reg;
    assign out_data.x_pos       = x_res;
    assign out_data.y_pos       = y_res;
    assign out_data.z_pos       = z4_reg;
    assign out_data.is_sidewalk = sw4_reg;

endmodule
